/* rtl/core/sfc_pkg.sv */
package sfc_pkg;

    localparam int SAMPLE_W         = 16;
    localparam int COEF_IDX_W       = 6;
    localparam int TAP_CNT_W        = 7;
    localparam int OUT_W            = 38;
    localparam int KIND_W           = 2;
    localparam int DEFAULT_MAX_TAPS = 64;
    localparam int QUEUE_DEPTH      = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_COEF   = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_FLUSH  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic signed [SAMPLE_W-1:0] value;
        logic [COEF_IDX_W-1:0]      coef_index;
    } item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] filtered_value;
        logic                    last;
    } result_t;

    typedef enum logic [1:0] {
        OP_COEF,
        OP_SHIFT,
        OP_CLEAR
    } op_kind_t;

    typedef struct packed {
        op_kind_t                   op;
        logic signed [SAMPLE_W-1:0] value;
        logic [COEF_IDX_W-1:0]      coef_index;
        logic                       last;
        logic                       clear;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic {
        FRONT_IDLE,
        FRONT_FLUSH
    } front_state_t;

endpackage

/* rtl/core/streaming_fir_convolver.sv */
// Channel   Dir   Beat      Handshake
// item      in    item_t    item_valid / item_stall
// result    out   result_t  result_valid / result_stall
// config    in    tap_count cfg_we / cfg_wdata
//
// A coefficient write or sample is one input beat; a flush stalls the input while
// it pushes max(1, taps-1) tail beats, one per cycle while the 4-entry queue has room.
// The back end issues one op per cycle while the queue is not empty and no result is
// stalled, into a full-width multiply row and a registered adder tree of log2(MAX_TAPS)
// levels; a shift op's sum passes the leaf row, each level, then the output register.
// Reset clears control, the delay line and tap_count (to 1); no clearing pass.
// A stalled result freezes the back end only; the front fills the queue meanwhile.
module streaming_fir_convolver
    import sfc_pkg::*;
#(
    parameter int MAX_TAPS = DEFAULT_MAX_TAPS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [TAP_CNT_W-1:0] cfg_wdata
);

    localparam int TAPS_W = $clog2(MAX_TAPS + 1);

    logic [TAP_CNT_W-1:0] tap_count_reg;
    logic [TAPS_W-1:0]    taps;
    queue_status_t        q_status;
    logic                 q_push;
    logic                 q_pop;
    op_t                  push_op;
    op_t                  head_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_CNT_W'(1);
        end
        else if (cfg_we)
        begin
            tap_count_reg <= cfg_wdata;
        end
    end

    // zero acts as one tap, anything above the store saturates
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            taps = TAPS_W'(1);
        end
        else if (int'(tap_count_reg) > MAX_TAPS)
        begin
            taps = TAPS_W'(MAX_TAPS);
        end
        else
        begin
            taps = TAPS_W'(tap_count_reg);
        end
    end

    sfc_front #(
        .MAX_TAPS (MAX_TAPS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .taps       (taps),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_status   (q_status),
        .push       (q_push),
        .push_op    (push_op)
    );

    sfc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (push_op),
        .pop     (q_pop),
        .head_op (head_op),
        .status  (q_status)
    );

    sfc_back #(
        .MAX_TAPS (MAX_TAPS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .taps         (taps),
        .q_status     (q_status),
        .head_op      (head_op),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("queue pop while empty");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> item_stall)
        else $error("input not stalled with queue full");

endmodule

/* rtl/core/sfc_queue.sv */
module sfc_queue
    import sfc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  op_t           push_op,
    input  logic          pop,
    output op_t           head_op,
    output queue_status_t status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_op      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

/* rtl/core/sfc_front.sv */
module sfc_front
    import sfc_pkg::*;
#(
    parameter int MAX_TAPS = DEFAULT_MAX_TAPS
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [$clog2(MAX_TAPS + 1)-1:0]    taps,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  item_t                              item,
    input  queue_status_t                      q_status,
    output logic                               push,
    output op_t                                push_op
);

    localparam int TAPS_W = $clog2(MAX_TAPS + 1);

    front_state_t      state_reg;
    front_state_t      state_next;
    logic [TAPS_W-1:0] remain_reg;
    logic [TAPS_W-1:0] remain_next;
    logic              accept;

    assign item_stall = (state_reg == FRONT_FLUSH) || q_status.full;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= FRONT_IDLE;
            remain_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            remain_reg <= remain_next;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        remain_next        = remain_reg;
        push               = 1'b0;
        push_op.op         = OP_SHIFT;
        push_op.value      = item.value;
        push_op.coef_index = item.coef_index;
        push_op.last       = 1'b0;
        push_op.clear      = 1'b0;
        unique case (state_reg)
            FRONT_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind_t'(item.kind))
                        KIND_COEF:
                        begin
                            push       = 1'b1;
                            push_op.op = OP_COEF;
                        end
                        KIND_SAMPLE:
                        begin
                            push = 1'b1;
                        end
                        KIND_FLUSH:
                        begin
                            push          = 1'b1;
                            push_op.value = '0;
                            if (taps == TAPS_W'(1))
                            begin
                                push_op.op = OP_CLEAR;
                            end
                            else if (taps == TAPS_W'(2))
                            begin
                                push_op.last  = 1'b1;
                                push_op.clear = 1'b1;
                            end
                            else
                            begin
                                // first tail beat goes now, the rest from FLUSH
                                state_next  = FRONT_FLUSH;
                                remain_next = taps - TAPS_W'(2);
                            end
                        end
                        default:
                        begin
                            // drop unused kind
                        end
                    endcase
                end
            end
            FRONT_FLUSH:
            begin
                push_op.value = '0;
                if (!q_status.full)
                begin
                    push          = 1'b1;
                    push_op.last  = (remain_reg == TAPS_W'(1));
                    push_op.clear = (remain_reg == TAPS_W'(1));
                    remain_next   = remain_reg - 1'b1;
                    if (remain_reg == TAPS_W'(1))
                    begin
                        state_next = FRONT_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = FRONT_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/sfc_back.sv */
module sfc_back
    import sfc_pkg::*;
#(
    parameter int MAX_TAPS = DEFAULT_MAX_TAPS
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [$clog2(MAX_TAPS + 1)-1:0]    taps,
    input  queue_status_t                      q_status,
    input  op_t                                head_op,
    output logic                               pop,
    output logic                               result_valid,
    input  logic                               result_stall,
    output result_t                            result
);

    localparam int IDX_W  = $clog2(MAX_TAPS);
    localparam int LEVELS = $clog2(MAX_TAPS);
    localparam int NLEAF  = 1 << LEVELS;
    localparam int NODES  = 2 * NLEAF - 1;
    localparam int PROD_W = 2 * SAMPLE_W;
    localparam int ACC_W  = PROD_W + LEVELS;
    localparam int EXT_W  = (ACC_W > OUT_W) ? ACC_W : OUT_W;

    logic signed [SAMPLE_W-1:0] coef_reg [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] dl_reg   [MAX_TAPS-1];
    logic signed [SAMPLE_W-1:0] win      [MAX_TAPS];
    logic signed [PROD_W-1:0]   prod     [MAX_TAPS];
    logic signed [ACC_W-1:0]    node_reg [NODES];
    logic [LEVELS:0]            vld_reg;
    logic [LEVELS:0]            last_reg;
    logic                       out_valid_reg;
    logic signed [OUT_W-1:0]    out_value_reg;
    logic                       out_last_reg;
    logic signed [EXT_W-1:0]    root_ext;
    logic [IDX_W-1:0]           wr_idx;
    logic                       adv;
    logic                       is_shift;
    logic                       wipe;

    // whole tree advances together; hold everything while a result waits
    assign adv      = !out_valid_reg || !result_stall;
    assign pop      = adv && !q_status.empty;
    assign is_shift = (head_op.op == OP_SHIFT);
    assign wipe     = (head_op.op == OP_CLEAR) || (is_shift && head_op.clear);
    assign wr_idx   = IDX_W'(head_op.coef_index);

    always_comb
    begin
        win[0] = head_op.value;
        for (int j = 1; j < MAX_TAPS; j++)
        begin
            win[j] = dl_reg[j-1];
        end
        for (int j = 0; j < MAX_TAPS; j++)
        begin
            prod[j] = win[j] * coef_reg[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && (head_op.op == OP_COEF) && (int'(head_op.coef_index) < MAX_TAPS))
        begin
            coef_reg[wr_idx] <= head_op.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TAPS - 1; i++)
            begin
                dl_reg[i] <= '0;
            end
        end
        else if (pop && wipe)
        begin
            for (int i = 0; i < MAX_TAPS - 1; i++)
            begin
                dl_reg[i] <= '0;
            end
        end
        else if (pop && is_shift)
        begin
            dl_reg[0] <= head_op.value;
            for (int i = 1; i < MAX_TAPS - 1; i++)
            begin
                dl_reg[i] <= dl_reg[i-1];
            end
        end
    end

    // adder tree in heap order: node k lives at k-1, leaves at NLEAF-1 and up
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < MAX_TAPS; j++)
            begin
                node_reg[NLEAF-1+j] <= (j < int'(taps)) ? ACC_W'(prod[j]) : '0;
            end
            for (int j = MAX_TAPS; j < NLEAF; j++)
            begin
                node_reg[NLEAF-1+j] <= '0;
            end
            for (int k = 1; k < NLEAF; k++)
            begin
                node_reg[k-1] <= node_reg[2*k-1] + node_reg[2*k];
            end
        end
    end

    assign root_ext = EXT_W'(node_reg[0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[LEVELS-1:0], pop && is_shift};
            last_reg      <= {last_reg[LEVELS-1:0], head_op.last};
            out_valid_reg <= vld_reg[LEVELS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_value_reg <= root_ext[OUT_W-1:0];
            out_last_reg  <= last_reg[LEVELS];
        end
    end

    assign result_valid          = out_valid_reg;
    assign result.filtered_value = out_value_reg;
    assign result.last           = out_last_reg;

endmodule
